// ===== rtl/core/gif_lzw_pixel_decoder_macros.svh =====
// assertion helpers for the lzw decoder checker
`ifndef GIF_LZW_PIXEL_DECODER_MACROS_SVH
`define GIF_LZW_PIXEL_DECODER_MACROS_SVH

// implication checked at every edge outside reset
`define GLZ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// implication checked in the cycle after the antecedent
`define GLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/core/glzd_pkg.sv =====
`default_nettype none
package glzd_pkg;
  localparam int TABLE_ENTRIES_D   = 4096;
  localparam int MAX_CODE_BITS_D   = 12;
  localparam int STACK_DEPTH_D     = 4096;
  localparam int BIT_BUFFER_BITS_D = 32;

  localparam logic [2:0] ST_TAKEN   = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_PIXEL   = 3'd2;
  localparam logic [2:0] ST_NEED    = 3'd3;
  localparam logic [2:0] ST_END     = 3'd4;
  localparam logic [2:0] ST_BAD     = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  localparam logic [2:0] REG_MIN_CODE  = 3'd0;
  localparam logic [2:0] REG_TRANS_EN  = 3'd1;
  localparam logic [2:0] REG_TRANS_IDX = 3'd2;
  localparam logic [2:0] REG_SCALE     = 3'd3;
  localparam logic [2:0] REG_LEFT_X    = 3'd4;
  localparam logic [2:0] REG_TOP_Y     = 3'd5;
  localparam logic [2:0] REG_WIDTH     = 3'd6;
  localparam logic [2:0] REG_HEIGHT    = 3'd7;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_PUSH_BYTE, OP_REFUSE, OP_HALTED, OP_CHECK, OP_POP_REQ, OP_POP_OUT,
    OP_TAKE_CODE, OP_EXPAND_START, OP_WALK_REQ, OP_WALK_STEP, OP_FINISH, OP_NEED,
    OP_CLEAR
  } glzd_op_t;

  typedef struct packed {
    glzd_op_t   op;
    logic [2:0] halt_st;
  } glzd_cmd_t;

  typedef struct packed {
    logic       is_byte;
    logic       refuse;
    logic       halted;
    logic       frame_done;
    logic       stack_empty;
    logic       need_data;
    logic       code_end;
    logic       code_clear;
    logic       code_bad;
    logic       walk_more;
  } glzd_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/glzd_if.sv =====
`default_nettype none
interface glzd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface glzd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  color_index;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic        draw;
  modport source (output valid, status, color_index, pos_x, pos_y, draw, input ready);
  modport sink (input valid, status, color_index, pos_x, pos_y, draw, output ready);
endinterface

interface glzd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gif_lzw_pixel_decoder.sv =====
// channel  direction  fields
// in_      sink       kind, data_byte
// out_     source     status, color_index, pos_x, pos_y, draw
// cfg_     sink       index (0..7), data
// a byte or a halted request passes the dispatch state back to idle; a
// pixel request pops a waiting pixel (one registered stack read), else it
// decodes codes (a clear code restarts the table) and walks table entries
// (one registered ram read each) until a result is ready
// reset (rst_n low, synchronous) restores most registers to defaults
// a result waits in the output register; a new item is taken once it leaves
`default_nettype none
module gif_lzw_pixel_decoder import glzd_pkg::*; #(
  parameter int TABLE_ENTRIES   = TABLE_ENTRIES_D,
  parameter int MAX_CODE_BITS   = MAX_CODE_BITS_D,
  parameter int STACK_DEPTH     = STACK_DEPTH_D,
  parameter int BIT_BUFFER_BITS = BIT_BUFFER_BITS_D
) (
  input wire logic   clk,
  input wire logic   rst_n,
  glzd_in_if.sink    in_ch,
  glzd_out_if.source out_ch,
  glzd_cfg_if.sink   cfg_ch
);
  glzd_cmd_t cmd;
  glzd_sts_t sts;
  logic in_fire, idle, out_valid;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = idle;
  assign out_ch.valid = out_valid;

  // control sequencer
  glzd_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid && !out_ch.ready),
    .sts, .cmd, .in_ready(in_ch.ready), .idle);

  // registers, bit buffer, table and stack
  glzd_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS),
    .STACK_DEPTH(STACK_DEPTH), .BIT_BUFFER_BITS(BIT_BUFFER_BITS)
  ) u_dp (
    .clk, .rst_n, .in_fire, .in_kind(in_ch.kind), .in_byte(in_ch.data_byte),
    .cfg_fire(cfg_ch.valid && cfg_ch.ready), .cfg_idx(cfg_ch.index),
    .cfg_val(cfg_ch.data), .cmd, .sts,
    .out_take(out_valid && out_ch.ready), .out_valid,
    .out_status(out_ch.status), .out_color(out_ch.color_index),
    .out_x(out_ch.pos_x), .out_y(out_ch.pos_y), .out_draw(out_ch.draw));
endmodule
`default_nettype wire

// ===== rtl/core/glzd_ram.sv =====
`default_nettype none
module glzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/glzd_ctrl.sv =====
`default_nettype none
module glzd_ctrl import glzd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire logic      out_busy,
  input  glzd_sts_t      sts,
  output glzd_cmd_t      cmd,
  output logic           in_ready,
  output logic           idle
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_LOOP   = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_DECODE = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_WALKW  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_busy;
  assign idle     = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.halt_st = ST_END;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_DISP;
      S_DISP: begin
        if (sts.is_byte) begin
          cmd.op = sts.refuse ? OP_REFUSE : OP_PUSH_BYTE;
          state_nxt = S_IDLE;
        end else if (sts.halted) begin
          cmd.op = OP_HALTED;
          state_nxt = S_IDLE;
        end else if (sts.frame_done) begin
          cmd.op = OP_CHECK;
          cmd.halt_st = ST_DONE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (!sts.stack_empty) begin
          cmd.op = OP_POP_REQ;
          state_nxt = S_POP;
        end else if (sts.need_data) begin
          cmd.op = OP_NEED;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_TAKE_CODE;
          state_nxt = S_DECODE;
        end
      end
      S_POP: begin
        cmd.op = OP_POP_OUT;
        state_nxt = S_IDLE;
      end
      S_DECODE: begin
        if (sts.code_end) begin
          cmd.op = OP_CHECK;
          cmd.halt_st = ST_END;
          state_nxt = S_IDLE;
        end else if (sts.code_clear) begin
          cmd.op = OP_CLEAR;
          state_nxt = S_LOOP;
        end else if (sts.code_bad) begin
          cmd.op = OP_CHECK;
          cmd.halt_st = ST_BAD;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = OP_EXPAND_START;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_more) begin
          cmd.op = OP_WALK_REQ;
          state_nxt = S_WALKW;
        end else begin
          cmd.op = OP_FINISH;
          state_nxt = S_LOOP;
        end
      end
      S_WALKW: begin
        cmd.op = OP_WALK_STEP;
        state_nxt = S_WALK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/glzd_datapath.sv =====
`default_nettype none
module glzd_datapath import glzd_pkg::*; #(
  parameter int TABLE_ENTRIES   = TABLE_ENTRIES_D,
  parameter int MAX_CODE_BITS   = MAX_CODE_BITS_D,
  parameter int STACK_DEPTH     = STACK_DEPTH_D,
  parameter int BIT_BUFFER_BITS = BIT_BUFFER_BITS_D
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_byte,
  input  wire logic        cfg_fire,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_val,
  input  glzd_cmd_t        cmd,
  output glzd_sts_t        sts,
  input  wire logic        out_take,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_color,
  output logic [15:0]      out_x,
  output logic [15:0]      out_y,
  output logic             out_draw
);
  localparam int TW  = $clog2(TABLE_ENTRIES);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int CW  = 13;
  localparam int BBW = BIT_BUFFER_BITS;
  localparam int BCW = $clog2(BIT_BUFFER_BITS + 1);

  logic [3:0]  min_code_r;
  logic        trans_en_r;
  logic [7:0]  trans_idx_r;
  logic [2:0]  scale_r;
  logic [15:0] left_x_r, top_y_r, width_r, height_r, cur_x_r, cur_y_r;

  logic [BBW-1:0] bbuf_r;
  logic [BCW-1:0] bcnt_r;
  logic [SW:0]    scnt_r;
  logic [3:0]     cwidth_r;
  logic [CW-1:0]  nfree_r, prev_r, code_r, walk_r, in_code_r;
  logic           prev_v_r;
  logic [7:0]     first_r;
  logic           halted_r;
  logic           kind_r;
  logic [7:0]     byte_r;
  logic [2:0]     halt_st_r;
  logic [15:0]    walk_guard_r;

  // clamped code size
  logic [3:0]  msz;
  logic [CW-1:0] clr;
  always_comb begin
    msz = min_code_r;
    if (msz < 4'd2) msz = 4'd2;
    if (msz > 4'(MAX_CODE_BITS - 1)) msz = 4'(MAX_CODE_BITS - 1);
    clr = CW'(1) << msz;
  end

  // memories
  logic          tbl_we, stk_we;
  logic [TW-1:0] tbl_waddr, tbl_raddr;
  logic [19:0]   tbl_wdata, tbl_rdata;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_rdata;

  glzd_ram #(.WIDTH(20), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata));
  glzd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  // status toward the controller
  logic [BCW:0]  bsum;
  logic [CW-1:0] code_now;
  logic [CW-1:0] cw_mask;
  assign bsum     = {1'b0, bcnt_r} + (BCW+1)'(8);
  assign cw_mask  = (CW'(1) << cwidth_r) - CW'(1);
  assign code_now = CW'(bbuf_r[CW-1:0]) & cw_mask;
  always_comb begin
    sts.is_byte     = !kind_r;
    sts.refuse      = bsum > (BCW+1)'(BBW);
    sts.halted      = halted_r;
    sts.frame_done  = (cur_y_r - top_y_r) >= height_r;
    sts.stack_empty = (scnt_r == '0);
    sts.need_data   = bcnt_r < BCW'(cwidth_r);
    sts.code_end    = code_r == clr + CW'(1);
    sts.code_clear  = code_r == clr;
    sts.code_bad    = (code_r > nfree_r) || (code_r == nfree_r && !prev_v_r);
    sts.walk_more   = (walk_r >= clr) && (walk_r < CW'(TABLE_ENTRIES)) &&
                      (walk_guard_r < 16'(TABLE_ENTRIES));
  end

  // push helper: writes stack at current count
  logic       push_en;
  logic [7:0] push_val;
  assign stk_we    = push_en && (scnt_r < (SW+1)'(STACK_DEPTH));
  assign stk_waddr = scnt_r[SW-1:0];
  assign stk_wdata = push_val;
  assign stk_raddr = SW'(scnt_r - (SW+1)'(1));

  logic [7:0] fc_final;
  assign fc_final = walk_r[7:0];
  logic       add_en;
  assign add_en   = (cmd.op == OP_FINISH) && prev_v_r && (nfree_r < CW'(TABLE_ENTRIES));
  assign tbl_we    = add_en;
  assign tbl_waddr = nfree_r[TW-1:0];
  assign tbl_wdata = {prev_r[11:0], fc_final};
  assign tbl_raddr = walk_r[TW-1:0];

  always_comb begin
    push_en  = 1'b0;
    push_val = 8'd0;
    unique case (cmd.op)
      OP_EXPAND_START: begin
        push_en  = (code_r == nfree_r);
        push_val = first_r;
      end
      OP_WALK_STEP: begin
        push_en  = 1'b1;
        push_val = tbl_rdata[7:0];
      end
      OP_FINISH: begin
        push_en  = 1'b1;
        push_val = fc_final;
      end
      default: ;
    endcase
  end

  logic [15:0] xinc;
  logic [15:0] smask;
  assign xinc  = cur_x_r + 16'd1;
  assign smask = (16'd1 << scale_r) - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_r <= 4'd8; trans_en_r <= 1'b0; trans_idx_r <= 8'd0; scale_r <= 3'd0;
      left_x_r <= '0; top_y_r <= '0; width_r <= 16'd1; height_r <= 16'd1;
      cur_x_r <= '0; cur_y_r <= '0;
      bbuf_r <= '0; bcnt_r <= '0; scnt_r <= '0;
      cwidth_r <= 4'd9; nfree_r <= CW'(258); prev_r <= '0; prev_v_r <= 1'b0;
      first_r <= '0; halted_r <= 1'b0; halt_st_r <= ST_TAKEN;
      out_valid <= 1'b0;
    end else begin
      if (out_take) out_valid <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_idx)
          REG_MIN_CODE: begin
            min_code_r <= cfg_val[3:0];
            // also restarts the dictionary, below
          end
          REG_TRANS_EN:  trans_en_r  <= cfg_val[0];
          REG_TRANS_IDX: trans_idx_r <= cfg_val[7:0];
          REG_SCALE:     scale_r     <= cfg_val[2:0];
          REG_LEFT_X:    begin left_x_r <= cfg_val; cur_x_r <= cfg_val; end
          REG_TOP_Y:     begin top_y_r <= cfg_val; cur_y_r <= cfg_val; end
          REG_WIDTH:     width_r  <= cfg_val;
          REG_HEIGHT:    height_r <= cfg_val;
          default: ;
        endcase
      end
      if (cfg_fire && cfg_idx == REG_MIN_CODE) begin
        cwidth_r <= ((cfg_val[3:0] < 4'd2) ? 4'd2 :
                     (cfg_val[3:0] > 4'(MAX_CODE_BITS - 1)) ? 4'(MAX_CODE_BITS - 1) :
                     cfg_val[3:0]) + 4'd1;
        nfree_r  <= (CW'(1) << ((cfg_val[3:0] < 4'd2) ? 4'd2 :
                     (cfg_val[3:0] > 4'(MAX_CODE_BITS - 1)) ? 4'(MAX_CODE_BITS - 1) :
                     cfg_val[3:0])) + CW'(2);
        prev_v_r <= 1'b0;
        prev_r   <= '0;
      end
      if (in_fire) begin
        kind_r <= in_kind;
        byte_r <= in_byte;
      end
      unique case (cmd.op)
        OP_PUSH_BYTE: begin
          bbuf_r    <= bbuf_r | (BBW'(byte_r) << bcnt_r);
          bcnt_r    <= bcnt_r + BCW'(8);
          out_valid <= 1'b1; out_status <= ST_TAKEN;
          out_color <= '0; out_x <= '0; out_y <= '0; out_draw <= 1'b0;
        end
        OP_REFUSE: begin
          out_valid <= 1'b1; out_status <= ST_REFUSED;
          out_color <= '0; out_x <= '0; out_y <= '0; out_draw <= 1'b0;
        end
        OP_HALTED: begin
          out_valid <= 1'b1; out_status <= halt_st_r;
          out_color <= '0; out_x <= '0; out_y <= '0; out_draw <= 1'b0;
        end
        OP_CHECK: begin
          halted_r  <= 1'b1; halt_st_r <= cmd.halt_st;
          // frame complete drops any waiting pixels
          if (cmd.halt_st == ST_DONE) scnt_r <= '0;
          out_valid <= 1'b1; out_status <= cmd.halt_st;
          out_color <= '0; out_x <= '0; out_y <= '0; out_draw <= 1'b0;
        end
        OP_NEED: begin
          out_valid <= 1'b1; out_status <= ST_NEED;
          out_color <= '0; out_x <= '0; out_y <= '0; out_draw <= 1'b0;
        end
        OP_POP_REQ: ;
        OP_POP_OUT: begin
          scnt_r     <= scnt_r - (SW+1)'(1);
          out_valid  <= 1'b1; out_status <= ST_PIXEL;
          out_color  <= stk_rdata;
          out_x      <= cur_x_r >> scale_r;
          out_y      <= cur_y_r >> scale_r;
          out_draw   <= ((cur_y_r & smask) == 16'd0) &&
                        !(trans_en_r && stk_rdata == trans_idx_r);
          if ((xinc - left_x_r) >= width_r) begin
            cur_x_r <= left_x_r;
            cur_y_r <= cur_y_r + 16'd1;
          end else begin
            cur_x_r <= xinc;
          end
        end
        OP_TAKE_CODE: begin
          code_r <= code_now;
          bbuf_r <= bbuf_r >> cwidth_r;
          bcnt_r <= bcnt_r - BCW'(cwidth_r);
        end
        // clear code restarts the dictionary
        OP_CLEAR: begin
          cwidth_r <= msz + 4'd1;
          nfree_r  <= clr + CW'(2);
          prev_v_r <= 1'b0;
          prev_r   <= '0;
        end
        OP_EXPAND_START: begin
          in_code_r    <= code_r;
          walk_guard_r <= '0;
          walk_r       <= (code_r == nfree_r) ? prev_r : code_r;
          if (stk_we) scnt_r <= scnt_r + (SW+1)'(1);
        end
        OP_WALK_REQ: ;
        OP_WALK_STEP: begin
          walk_r       <= CW'(tbl_rdata[19:8]);
          walk_guard_r <= walk_guard_r + 16'd1;
          if (stk_we) scnt_r <= scnt_r + (SW+1)'(1);
        end
        OP_FINISH: begin
          first_r <= fc_final;
          if (stk_we) scnt_r <= scnt_r + (SW+1)'(1);
          if (add_en) begin
            nfree_r <= nfree_r + CW'(1);
            if ((nfree_r + CW'(1)) == (CW'(1) << cwidth_r) &&
                cwidth_r < 4'(MAX_CODE_BITS))
              cwidth_r <= cwidth_r + 4'd1;
          end
          prev_r   <= in_code_r;
          prev_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/glzd_checker.sv =====
`default_nettype none
`include "gif_lzw_pixel_decoder_macros.svh"
module glzd_checker import glzd_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic       out_draw
);
  `GLZ_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status != 3'd7)
  `GLZ_ASSERT_IMP(a_draw_pixel, clk, rst_n, out_valid && out_draw, out_status == ST_PIXEL)
  `GLZ_ASSERT_NEXT(a_no_result_early, clk, rst_n, in_valid && in_ready, !out_valid || $past(out_valid))
  `GLZ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind gif_lzw_pixel_decoder glzd_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_draw(out_ch.draw));
`default_nettype wire
